@@ hdl/mbh_pkg.sv @@
package mbh_pkg;

  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD  = 32'he6546b64;
  localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;
  localparam logic [31:0] SIGN_CLEAR = 32'h7FFFFFFF;
  localparam int unsigned DIV_STEPS  = 31;

  // configuration register indexes
  localparam logic CFG_SEED    = 1'b0;
  localparam logic CFG_BUCKETS = 1'b1;

  localparam logic [30:0] BUCKETS_RESET = 31'd16;

  typedef enum logic [3:0] {
    S_ACCEPT,
    S_WMUL1,
    S_WMUL2,
    S_WROUND,
    S_TMUL1,
    S_TMUL2,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_DIV,
    S_OUT
  } mbh_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_WMUL1,
    OP_WMUL2,
    OP_WROUND,
    OP_TMUL1,
    OP_TMUL2,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_DIV,
    OP_OUT
  } mbh_op_t;

  typedef struct packed {
    mbh_op_t op;
  } mbh_cmd_t;

  typedef struct packed {
    logic bytes_full;
    logic div_done;
    logic out_free;
  } mbh_status_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

endpackage

@@ hdl/mbh_ctrl.sv @@
module mbh_ctrl
  import mbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        byte_present,
  input  logic        last_of_key,
  input  mbh_status_t status,
  output mbh_cmd_t    cmd,
  output logic        in_stall
);

  mbh_state_t state, state_next;
  logic       last_pending, last_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_ACCEPT;
      last_pending <= 1'b0;
    end else begin
      state        <= state_next;
      last_pending <= last_pending_next;
    end
  end

  always_comb begin
    state_next        = state;
    last_pending_next = last_pending;
    cmd.op            = OP_NONE;
    in_stall          = 1'b1;
    case (state)
      S_ACCEPT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (byte_present && status.bytes_full) begin
            last_pending_next = last_of_key;
            state_next        = S_WMUL1;
          end else if (last_of_key) begin
            state_next = S_TMUL1;
          end
        end
      end
      S_WMUL1: begin
        cmd.op     = OP_WMUL1;
        state_next = S_WMUL2;
      end
      S_WMUL2: begin
        cmd.op     = OP_WMUL2;
        state_next = S_WROUND;
      end
      S_WROUND: begin
        cmd.op     = OP_WROUND;
        state_next = last_pending ? S_TMUL1 : S_ACCEPT;
      end
      S_TMUL1: begin
        cmd.op     = OP_TMUL1;
        state_next = S_TMUL2;
      end
      S_TMUL2: begin
        cmd.op     = OP_TMUL2;
        state_next = S_FIN1;
      end
      S_FIN1: begin
        cmd.op     = OP_FIN1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        cmd.op     = OP_FIN2;
        state_next = S_FIN3;
      end
      S_FIN3: begin
        cmd.op     = OP_FIN3;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op            = OP_OUT;
          last_pending_next = 1'b0;
          state_next        = S_ACCEPT;
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

endmodule

@@ hdl/mbh_dp.sv @@
module mbh_dp
  import mbh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  mbh_cmd_t     cmd,
  output mbh_status_t  status,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic [7:0]   key_byte,
  input  logic         byte_present,
  input  logic         last_of_key,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  hash_value,
  output logic [30:0]  bucket_index
);

  logic [31:0] hash_seed;
  logic [30:0] bucket_count;

  logic [31:0] hash_state;
  logic [23:0] partial_word;
  logic [1:0]  bytes_in_word;
  logic [31:0] key_length;
  logic        in_key;
  logic [31:0] k_reg;
  logic [31:0] fmix;
  logic [31:0] hash_final;
  logic [30:0] dvd;
  logic [31:0] rem;
  logic [4:0]  div_cnt;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] pre_fin, fold, round_x, fin_out;
  logic [31:0] rem_sh, div_sub;
  logic        div_ge;

  // shared multiplier, operand picked by the running step
  always_comb begin
    pre_fin = hash_state ^ (bytes_in_word != 2'd0 ? k_reg : 32'd0) ^ key_length;
    mul_a   = 32'd0;
    mul_b   = 32'd0;
    case (cmd.op)
      OP_WMUL1: begin
        mul_a = k_reg;
        mul_b = MIX_C1;
      end
      OP_TMUL1: begin
        mul_a = {8'd0, partial_word};
        mul_b = MIX_C1;
      end
      OP_WMUL2, OP_TMUL2: begin
        mul_a = rotl15(k_reg);
        mul_b = MIX_C2;
      end
      OP_FIN1: begin
        mul_a = pre_fin ^ (pre_fin >> 16);
        mul_b = FMIX_C1;
      end
      OP_FIN2: begin
        mul_a = fmix ^ (fmix >> 13);
        mul_b = FMIX_C2;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign fold    = hash_state ^ k_reg;
  assign round_x = rotl13(fold);
  assign fin_out = fmix ^ (fmix >> 16);

  // one restoring division step per cycle
  assign rem_sh  = {rem[30:0], dvd[30]};
  assign div_ge  = rem_sh >= {1'b0, bucket_count};
  assign div_sub = rem_sh - {1'b0, bucket_count};

  assign status.bytes_full = bytes_in_word == 2'd3;
  assign status.div_done   = div_cnt == 5'(DIV_STEPS - 1);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed    <= 32'd0;
      bucket_count <= BUCKETS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEED:    hash_seed    <= cfg_data;
        CFG_BUCKETS: bucket_count <= cfg_data[30:0];
        default:     hash_seed    <= hash_seed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_state    <= 32'd0;
      partial_word  <= 24'd0;
      bytes_in_word <= 2'd0;
      key_length    <= 32'd0;
      in_key        <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (byte_present || last_of_key) begin
            in_key <= 1'b1;
            if (!in_key) begin
              hash_state <= hash_seed;
            end
            if (byte_present) begin
              key_length <= key_length + 32'd1;
              if (bytes_in_word == 2'd3) begin
                partial_word  <= 24'd0;
                bytes_in_word <= 2'd0;
              end else begin
                partial_word  <= partial_word |
                                 (24'(key_byte) << {bytes_in_word, 3'b000});
                bytes_in_word <= bytes_in_word + 2'd1;
              end
            end
          end
        end
        OP_WROUND: begin
          hash_state <= round_x + {round_x[29:0], 2'b00} + ROUND_ADD;
        end
        OP_OUT: begin
          hash_state    <= hash_seed;
          partial_word  <= 24'd0;
          bytes_in_word <= 2'd0;
          key_length    <= 32'd0;
          in_key        <= 1'b0;
        end
        default: begin
          in_key <= in_key;
        end
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        k_reg <= {key_byte, partial_word};
      end
      OP_WMUL1, OP_WMUL2, OP_TMUL1, OP_TMUL2: begin
        k_reg <= prod;
      end
      OP_FIN1, OP_FIN2: begin
        fmix <= prod;
      end
      OP_FIN3: begin
        hash_final <= fin_out;
        dvd        <= fin_out[30:0];
        rem        <= 32'd0;
        div_cnt    <= 5'd0;
      end
      OP_DIV: begin
        rem     <= div_ge ? div_sub : rem_sh;
        dvd     <= {dvd[29:0], 1'b0};
        div_cnt <= div_cnt + 5'd1;
      end
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      hash_value   <= hash_final;
      bucket_index <= (bucket_count == 31'd0) ? 31'd0 : rem[30:0];
    end
  end

endmodule

@@ hdl/murmur3_bucket_hash.sv @@
// channel   direction  handshake              payload
// in        request    in_valid / in_stall    key_byte, byte_present, last_of_key
// out       result     out_valid / out_stall  hash_value, bucket_index
// cfg       write      cfg_write              cfg_index, cfg_data
//
// a byte that does not complete a word is only stored in the accept state, and
// a byte that completes a word runs two multiplies through the shared multiplier
// and then the round fold; end of key runs the tail scramble and final mix, then
// the restoring divider for the bucket, then loads the output
// rst is synchronous and clears config to seed 0, 16 buckets and empty key
// a held result blocks only at the next key end; that key's bytes stream in
module murmur3_bucket_hash
  import mbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key_byte,
  input  logic        byte_present,
  input  logic        last_of_key,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] hash_value,
  output logic [30:0] bucket_index
);

  mbh_cmd_t    cmd;
  mbh_status_t status;
  logic [31:0] hash_bits;

  // sequencer: accept, word rounds, tail, final mix, divide, output load
  mbh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .byte_present (byte_present),
    .last_of_key  (last_of_key),
    .status       (status),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  // hash state, shared multiplier, divider and output register
  mbh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .last_of_key  (last_of_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_bits),
    .bucket_index (bucket_index)
  );

  // hash leaves as two's complement
  assign hash_value = signed'(hash_bits);

endmodule
